// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the formatter's checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define HFF_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hff: same-cycle check failed");

// Next-cycle implication, masked during reset.
`define HFF_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hff: next-cycle check failed");

`endif

// File: rtl/hff_pkg.sv
// ----------------------------------------------------------------------------
// hff_pkg
// Beat types, microcode word layout and microprogram for the hex formatter.
// ----------------------------------------------------------------------------
package hff_pkg;

  typedef struct packed {
    logic [31:0] value;
    logic [6:0]  width;
    logic [5:0]  precision;
    logic        has_precision;
    logic        left_justify;
    logic        zero_pad;
    logic        alt_form;
    logic        uppercase;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] character;
    logic [5:0] position;
    logic       last;
  } out_beat_t;

  // character source of a step
  typedef enum logic [1:0] {
    SRC_SPACE = 2'd0,
    SRC_ZERO  = 2'd1,
    SRC_X     = 2'd2,
    SRC_DIGIT = 2'd3
  } src_t;

  // repeat count of a step
  typedef enum logic [1:0] {
    CNT_ONE    = 2'd0,
    CNT_PAD    = 2'd1,
    CNT_ZEROS  = 2'd2,
    CNT_DIGITS = 2'd3
  } cnt_sel_t;

  // step is skipped when its condition is false
  typedef enum logic [2:0] {
    COND_ALWAYS = 3'd0,
    COND_LEAD   = 3'd1,
    COND_PREFIX = 3'd2,
    COND_ZFILL  = 3'd3,
    COND_LEFT   = 3'd4
  } cond_t;

  localparam int PcW = 4;

  localparam logic [PcW-1:0] PC_IDLE  = 4'd0;
  localparam logic [PcW-1:0] PC_CALC  = 4'd1;
  localparam logic [PcW-1:0] PC_LEAD  = 4'd2;
  localparam logic [PcW-1:0] PC_PFX0  = 4'd3;
  localparam logic [PcW-1:0] PC_PFXX  = 4'd4;
  localparam logic [PcW-1:0] PC_ZPAD  = 4'd5;
  localparam logic [PcW-1:0] PC_PREC  = 4'd6;
  localparam logic [PcW-1:0] PC_DIG   = 4'd7;
  localparam logic [PcW-1:0] PC_TRAIL = 4'd8;

  typedef struct packed {
    src_t           src;
    cnt_sel_t       cnt_sel;
    cond_t          cond;
    logic           calc;
    logic [PcW-1:0] jump;
  } ucode_t;

  // sequencer -> datapath
  typedef struct packed {
    logic       load;
    logic       calc;
    logic       emit;
    src_t       src;
    logic [2:0] digit_idx;
  } ctrl_t;

  // datapath -> sequencer
  typedef struct packed {
    logic [6:0] pad;
    logic [5:0] zeros;
    logic [3:0] ndig;
    logic       lead_space;
    logic       prefix;
    logic       zero_fill;
    logic       left;
    logic       can_emit;
  } stat_t;

  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_X_LOWER = 8'h78;
  localparam logic [7:0] CHAR_X_UPPER = 8'h58;

  function automatic ucode_t ucode_rom(input logic [PcW-1:0] pc);
    ucode_t w;
    w = '{src: SRC_SPACE, cnt_sel: CNT_ONE, cond: COND_ALWAYS, calc: 1'b0,
          jump: PC_IDLE};
    unique case (pc)
      PC_IDLE:  w = '{SRC_SPACE, CNT_ONE,    COND_ALWAYS, 1'b0, PC_CALC};
      PC_CALC:  w = '{SRC_SPACE, CNT_ONE,    COND_ALWAYS, 1'b1, PC_LEAD};
      PC_LEAD:  w = '{SRC_SPACE, CNT_PAD,    COND_LEAD,   1'b0, PC_PFX0};
      PC_PFX0:  w = '{SRC_ZERO,  CNT_ONE,    COND_PREFIX, 1'b0, PC_PFXX};
      PC_PFXX:  w = '{SRC_X,     CNT_ONE,    COND_PREFIX, 1'b0, PC_ZPAD};
      PC_ZPAD:  w = '{SRC_ZERO,  CNT_PAD,    COND_ZFILL,  1'b0, PC_PREC};
      PC_PREC:  w = '{SRC_ZERO,  CNT_ZEROS,  COND_ALWAYS, 1'b0, PC_DIG};
      PC_DIG:   w = '{SRC_DIGIT, CNT_DIGITS, COND_ALWAYS, 1'b0, PC_TRAIL};
      PC_TRAIL: w = '{SRC_SPACE, CNT_PAD,    COND_LEFT,   1'b0, PC_IDLE};
      default:  w = '{SRC_SPACE, CNT_ONE,    COND_ALWAYS, 1'b0, PC_IDLE};
    endcase
    return w;
  endfunction

  // ASCII of one hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = CHAR_ZERO + {4'd0, nib};
    end else if (upper) begin
      c = 8'h37 + {4'd0, nib};
    end else begin
      c = 8'h57 + {4'd0, nib};
    end
    return c;
  endfunction

endpackage

// File: rtl/hff_sequencer.sv
// ----------------------------------------------------------------------------
// hff_sequencer
// Step counter, microprogram table and repeat counter of the formatter.
// ----------------------------------------------------------------------------
module hff_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  hff_pkg::stat_t  stat,
  output hff_pkg::ctrl_t  ctrl
);

  logic [hff_pkg::PcW-1:0] pc, pc_next;
  logic                    fresh, fresh_next;
  logic [6:0]              run, run_next;
  logic [6:0]              run_m1;
  logic [6:0]              cnt;
  logic                    cond_ok;
  hff_pkg::ucode_t         uw;

  assign uw     = hff_pkg::ucode_rom(pc);
  assign run_m1 = run - 7'd1;

  always_comb begin
    unique case (uw.cnt_sel)
      hff_pkg::CNT_ONE:    cnt = 7'd1;
      hff_pkg::CNT_PAD:    cnt = stat.pad;
      hff_pkg::CNT_ZEROS:  cnt = {1'b0, stat.zeros};
      hff_pkg::CNT_DIGITS: cnt = {3'd0, stat.ndig};
      default:             cnt = 7'd0;
    endcase
    unique case (uw.cond)
      hff_pkg::COND_ALWAYS: cond_ok = 1'b1;
      hff_pkg::COND_LEAD:   cond_ok = stat.lead_space;
      hff_pkg::COND_PREFIX: cond_ok = stat.prefix;
      hff_pkg::COND_ZFILL:  cond_ok = stat.zero_fill;
      hff_pkg::COND_LEFT:   cond_ok = stat.left;
      default:              cond_ok = 1'b0;
    endcase
  end

  always_comb begin
    pc_next        = pc;
    fresh_next     = fresh;
    run_next       = run;
    in_ready       = (pc == hff_pkg::PC_IDLE);
    ctrl.load      = 1'b0;
    ctrl.calc      = 1'b0;
    ctrl.emit      = 1'b0;
    ctrl.src       = uw.src;
    ctrl.digit_idx = run_m1[2:0];
    priority if (pc == hff_pkg::PC_IDLE) begin
      if (in_valid) begin
        ctrl.load = 1'b1;
        pc_next   = uw.jump;
      end
    end else if (uw.calc) begin
      ctrl.calc  = 1'b1;
      pc_next    = uw.jump;
      fresh_next = 1'b1;
    end else if (fresh) begin
      // step entry: skip, or load the repeat count
      if (!cond_ok || cnt == 7'd0) begin
        pc_next = uw.jump;
      end else begin
        run_next   = cnt;
        fresh_next = 1'b0;
      end
    end else if (stat.can_emit) begin
      ctrl.emit = 1'b1;
      run_next  = run_m1;
      if (run == 7'd1) begin
        pc_next    = uw.jump;
        fresh_next = 1'b1;
      end
    end else begin
      // output register still full: hold on the current character
      run_next = run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc    <= hff_pkg::PC_IDLE;
      fresh <= 1'b1;
      run   <= 7'd0;
    end else begin
      pc    <= pc_next;
      fresh <= fresh_next;
      run   <= run_next;
    end
  end

endmodule

// File: rtl/hff_datapath.sv
// ----------------------------------------------------------------------------
// hff_datapath
// Operand registers, field length arithmetic and output beat register.
// ----------------------------------------------------------------------------
module hff_datapath #(
  parameter int MAX_FIELD = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  hff_pkg::in_beat_t   in_data,
  input  hff_pkg::ctrl_t      ctrl,
  output hff_pkg::stat_t      stat,
  output logic                out_valid,
  input  logic                out_ready,
  output hff_pkg::out_beat_t  out_data
);

  localparam logic [6:0] WidthCap = 7'(MAX_FIELD);
  localparam logic [6:0] PrecCap  = 7'(MAX_FIELD - 2);

  // operands held for the whole field
  logic [31:0] value;
  logic [6:0]  width;
  logic [5:0]  prec;
  logic        has_prec, left, zpad, alt, upper;
  logic [3:0]  ndig;

  // derived at the calc step
  logic [5:0]  zeros;
  logic [6:0]  pad;
  logic [6:0]  total;
  logic        prefix;
  logic [5:0]  pos;

  logic [3:0]  ndig_load;
  logic [6:0]  digs, body;
  logic [7:0]  chr;
  logic [3:0]  nib;

  always_comb begin
    ndig_load = 4'd1;
    for (int i = 1; i < 8; i++) begin
      if (in_data.value[4*i +: 4] != 4'd0) ndig_load = 4'(i + 1);
    end
    if (in_data.has_precision && in_data.precision == 6'd0 && in_data.value == 32'd0) begin
      ndig_load = 4'd0;
    end
  end

  assign digs = (has_prec && {1'b0, prec} > {3'd0, ndig}) ? {1'b0, prec} : {3'd0, ndig};
  assign body = digs + ((alt && value != 32'd0) ? 7'd2 : 7'd0);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      value    <= in_data.value;
      width    <= (in_data.width > WidthCap) ? WidthCap : in_data.width;
      prec     <= ({1'b0, in_data.precision} > PrecCap) ? PrecCap[5:0] : in_data.precision;
      has_prec <= in_data.has_precision;
      left     <= in_data.left_justify;
      zpad     <= in_data.zero_pad;
      alt      <= in_data.alt_form;
      upper    <= in_data.uppercase;
      ndig     <= ndig_load;
    end
    if (ctrl.calc) begin
      zeros  <= 6'(digs - {3'd0, ndig});
      prefix <= alt && value != 32'd0;
      pad    <= (width > body) ? width - body : 7'd0;
      total  <= (width > body) ? width : body;
    end
  end

  assign nib = value[{ctrl.digit_idx, 2'b00} +: 4];

  always_comb begin
    unique case (ctrl.src)
      hff_pkg::SRC_SPACE: chr = hff_pkg::CHAR_SPACE;
      hff_pkg::SRC_ZERO:  chr = hff_pkg::CHAR_ZERO;
      hff_pkg::SRC_X:     chr = upper ? hff_pkg::CHAR_X_UPPER : hff_pkg::CHAR_X_LOWER;
      hff_pkg::SRC_DIGIT: chr = hff_pkg::hex_char(nib, upper);
      default:            chr = hff_pkg::CHAR_SPACE;
    endcase
  end

  assign stat.pad        = pad;
  assign stat.zeros      = zeros;
  assign stat.ndig       = ndig;
  assign stat.lead_space = !left && !(zpad && !has_prec);
  assign stat.prefix     = prefix;
  assign stat.zero_fill  = !left && zpad && !has_prec;
  assign stat.left       = left;
  assign stat.can_emit   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= 6'd0;
    end else begin
      if (ctrl.load) begin
        pos <= 6'd0;
      end else if (ctrl.emit) begin
        pos <= pos + 6'd1;
      end
      if (ctrl.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_data.character <= chr;
      out_data.position  <= pos;
      out_data.last      <= ({1'b0, pos} + 7'd1) == total;
    end
  end

endmodule

// File: rtl/hex_field_formatter.sv
// ----------------------------------------------------------------------------
// hex_field_formatter
// printf-style %x/%X field formatter: one value in, its characters out.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake              payload
//   in       in   in_valid / in_ready    hff_pkg::in_beat_t  (value and flags)
//   out      out  out_valid / out_ready  hff_pkg::out_beat_t (char, pos, last)
//
// With no output stall an item passes through the accept step, a calc step
// and an entry step for each of the seven segment steps of the
// microprogram, then emits one character per cycle. in_ready stays low
// until the program ends, so a field holds off the next input; a stalled
// output holds the sequencer on its current character.
// Reset (rst, synchronous) returns the step counter to idle and empties the
// output register; no clearing pass is needed.
// in_ready rises as soon as the program ends, while the last beat may still
// wait in the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hex_field_formatter #(
  parameter int MAX_FIELD = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  hff_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hff_pkg::out_beat_t  out_data
);

  hff_pkg::ctrl_t ctrl;
  hff_pkg::stat_t stat;

  // step counter, microcode table and repeat count
  hff_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  // operands, length arithmetic, character select, output beat
  hff_datapath #(
    .MAX_FIELD (MAX_FIELD)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .ctrl      (ctrl),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // no character while the program is idle
  `HFF_ASSERT_IMP(a_idle_quiet, clk, rst, in_ready, !ctrl.emit)
  // a character is only written over an empty or departing beat
  `HFF_ASSERT_IMP(a_no_overwrite, clk, rst, ctrl.emit, !out_valid || out_ready)
  // an accepted item is followed by the calc step
  `HFF_ASSERT_NXT(a_calc_after_load, clk, rst, in_valid && in_ready, ctrl.calc)
  // after a non-final character the program is still running
  `HFF_ASSERT_NXT(a_busy_mid_field, clk, rst, ctrl.emit, in_ready ? out_data.last : 1'b1)

endmodule

// File: verif/tb_hex_field_formatter.sv
// ----------------------------------------------------------------------------
// tb_hex_field_formatter
// Self-checking bench for the printf-style hex field formatter.
// ----------------------------------------------------------------------------
// A scoreboard class formats each accepted request in software and queues the
// characters it expects. Every output beat is then checked against the oldest
// queued character, field by field. The stimulus starts with directed corner
// cases and then sends random requests. The sender works in bursts with random
// gaps, and the receiver moves between several stall patterns of its own.
// ----------------------------------------------------------------------------
module tb_hex_field_formatter;

  localparam int MAX_FIELD    = 64;
  localparam int CYCLE        = 12;
  localparam int RESET_CYCLES = 11;
  localparam int RANDOM_REQS  = 300;
  // worst field of 64 chars plus the sequencer overhead
  localparam int SETTLE       = MAX_FIELD + 16;

  // receiver stall behaviour, changed at random intervals
  typedef enum logic [1:0] {
    RDY_ALWAYS = 2'd0,
    RDY_MOSTLY = 2'd1,
    RDY_RARELY = 2'd2,
    RDY_RING   = 2'd3
  } rdy_mode_t;

  // --------------------------------------------------------------------------
  // Scoreboard: formats a request into the characters it should produce and
  // checks output beats against them in order.
  // --------------------------------------------------------------------------
  class field_chars_sb;
    hff_pkg::out_beat_t expected_chars[$];
    int unsigned        mismatches = 0;
    string              lower_digits = "0123456789abcdef";
    string              upper_digits = "0123456789ABCDEF";

    function int unsigned pending();
      return expected_chars.size();
    endfunction

    // Work out the field for one accepted request and queue its characters.
    function void note_request(hff_pkg::in_beat_t req);
      int unsigned        fwidth, fprec, ndig, zeros, prefix, body, pad;
      logic [31:0]        v;
      logic [3:0]         nib;
      bit                 fill0;
      logic [7:0]         chars[$];
      hff_pkg::out_beat_t beat;

      fwidth = (req.width > MAX_FIELD) ? MAX_FIELD : req.width;
      fprec  = (req.precision > MAX_FIELD - 2) ? MAX_FIELD - 2 : req.precision;

      // minimal digit count; a zero value with precision zero prints nothing
      ndig = 1;
      v = req.value;
      while (v >= 32'd16) begin
        v = v >> 4;
        ndig++;
      end
      if (req.has_precision && fprec == 0 && req.value == 32'd0) ndig = 0;

      zeros  = (req.has_precision && fprec > ndig) ? fprec - ndig : 0;
      prefix = (req.alt_form && req.value != 32'd0) ? 2 : 0;
      body   = ndig + zeros + prefix;
      pad    = (fwidth > body) ? fwidth - body : 0;
      // left-justify and a given precision both cancel zero padding
      fill0  = req.zero_pad && !req.has_precision && !req.left_justify;

      if (!req.left_justify && !fill0) repeat (pad) chars.push_back(hff_pkg::CHAR_SPACE);
      if (prefix != 0) begin
        chars.push_back(hff_pkg::CHAR_ZERO);
        chars.push_back(req.uppercase ? hff_pkg::CHAR_X_UPPER : hff_pkg::CHAR_X_LOWER);
      end
      if (fill0) repeat (pad) chars.push_back(hff_pkg::CHAR_ZERO);
      repeat (zeros) chars.push_back(hff_pkg::CHAR_ZERO);
      for (int i = ndig; i > 0; i--) begin
        nib = 4'(req.value >> (4 * (i - 1)));
        chars.push_back(req.uppercase ? upper_digits[nib] : lower_digits[nib]);
      end
      if (req.left_justify) repeat (pad) chars.push_back(hff_pkg::CHAR_SPACE);

      foreach (chars[i]) begin
        beat.character = chars[i];
        beat.position  = i[5:0];
        beat.last      = (i == chars.size() - 1);
        expected_chars.push_back(beat);
      end
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $time, msg);
    endfunction

    // Compare one output beat with the oldest expected character.
    function void check_char(hff_pkg::out_beat_t got);
      hff_pkg::out_beat_t want;
      if (expected_chars.size() == 0) begin
        report($sformatf("unexpected char %02h pos %0d last %0b",
                         got.character, got.position, got.last));
        return;
      end
      want = expected_chars.pop_front();
      if (got.character !== want.character || got.position !== want.position ||
          got.last !== want.last) begin
        report($sformatf({"mismatch: expected char %02h pos %0d last %0b, ",
                          "got char %02h pos %0d last %0b"},
                         want.character, want.position, want.last,
                         got.character, got.position, got.last));
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block
  // --------------------------------------------------------------------------
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  hff_pkg::in_beat_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  hff_pkg::out_beat_t out_data;

  field_chars_sb     sb = new();
  hff_pkg::in_beat_t stim_q[$];

  always begin
    #(CYCLE / 2) clk = 1'b1;
    #(CYCLE / 2) clk = 1'b0;
  end

  hex_field_formatter #(
    .MAX_FIELD(MAX_FIELD)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // --------------------------------------------------------------------------
  // Monitor: both channels are sampled at the edge, before the block's
  // registers move, so accepted beats are seen exactly once.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_request(in_data);
      if (out_valid && out_ready) sb.check_char(out_data);
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall pattern switches mode after a random number of cycles.
  // --------------------------------------------------------------------------
  rdy_mode_t   rdy_mode = RDY_ALWAYS;
  int unsigned rdy_left = 0;
  logic [7:0]  rdy_ring = 8'b1011_0110;

  always @(posedge clk) begin
    if (rdy_left == 0) begin
      rdy_mode <= rdy_mode_t'($urandom_range(0, 3));
      rdy_left <= $urandom_range(20, 300);
    end else begin
      rdy_left <= rdy_left - 1;
    end
    rdy_ring <= {rdy_ring[0], rdy_ring[7:1]};
    case (rdy_mode)
      RDY_ALWAYS: out_ready <= 1'b1;
      RDY_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
      RDY_RARELY: out_ready <= ($urandom_range(0, 3) == 0);
      default:    out_ready <= rdy_ring[0];
    endcase
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic add_req(input logic [31:0] value, input logic [6:0] width,
                         input logic [5:0] prec, input logic hp, input logic lj,
                         input logic zp, input logic af, input logic uc);
    hff_pkg::in_beat_t r;
    r.value         = value;
    r.width         = width;
    r.precision     = prec;
    r.has_precision = hp;
    r.left_justify  = lj;
    r.zero_pad      = zp;
    r.alt_form      = af;
    r.uppercase     = uc;
    stim_q.push_back(r);
  endtask

  // Mostly short fields; now and then a wide one or a saturating width.
  function automatic hff_pkg::in_beat_t random_req();
    hff_pkg::in_beat_t r;
    int unsigned       pick;
    r = '0;
    pick = $urandom_range(0, 9);
    if (pick == 0)      r.value = 32'd0;
    else if (pick == 1) r.value = 32'hFFFF_FFFF;
    else                r.value = $urandom >> $urandom_range(0, 31);
    pick = $urandom_range(0, 19);
    if (pick < 15)      r.width = 7'($urandom_range(0, 20));
    else if (pick < 19) r.width = 7'($urandom_range(0, 64));
    else                r.width = 7'($urandom_range(65, 127));
    if ($urandom_range(0, 9) < 7) r.precision = 6'($urandom_range(0, 12));
    else                          r.precision = 6'($urandom_range(0, 63));
    r.has_precision = 1'($urandom_range(0, 1));
    r.left_justify  = 1'($urandom_range(0, 1));
    r.zero_pad      = 1'($urandom_range(0, 1));
    r.alt_form      = 1'($urandom_range(0, 1));
    r.uppercase     = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // Drive one request and hold it until the block takes it.
  task automatic send_req(input hff_pkg::in_beat_t req);
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned burst, gap, idx;

    // directed corners: value, width, prec, has_prec, left, zpad, alt, upper
    add_req(32'h0000_0000,  7'd0,  6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0); // plain zero
    add_req(32'h0000_0000,  7'd0,  6'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0); // empty field
    add_req(32'h0000_0000,  7'd5,  6'd0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0); // spaces only
    add_req(32'h0000_0000,  7'd8,  6'd0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0); // zero, no prefix
    add_req(32'h0000_0000,  7'd0,  6'd3, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    add_req(32'hFFFF_FFFF,  7'd0,  6'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
    add_req(32'hDEAD_BEEF,  7'd16, 6'd0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
    add_req(32'h0000_1A2B,  7'd12, 6'd0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0); // left beats zpad
    add_req(32'h0000_0ABC,  7'd14, 6'd8, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1); // prec beats zpad
    add_req(32'h1234_5678,  7'd127, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0); // width saturates
    add_req(32'h1234_5678,  7'd127, 6'd63, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1); // both saturate
    add_req(32'h0000_00FF,  7'd64, 6'd63, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0);
    add_req(32'h0000_00FF,  7'd4,  6'd63, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0); // prec ignored
    add_req(32'h0000_0010,  7'd64, 6'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    add_req(32'h0000_0010,  7'd64, 6'd0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
    add_req(32'h89AB_CDEF,  7'd0,  6'd4, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0); // prec < digits
    add_req(32'h0ABC_DEF0,  7'd3,  6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1); // width < body
    add_req(32'h0000_CAFE,  7'd10, 6'd6, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    add_req(32'h0000_0001,  7'd0,  6'd0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
    add_req(32'h8000_0000,  7'd11, 6'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
    add_req(32'h7654_3210,  7'd9,  6'd10, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);

    repeat (RANDOM_REQS) stim_q.push_back(random_req());

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // bursts of back-to-back requests, some long, separated by random gaps
    idx = 0;
    while (idx < stim_q.size()) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      while (burst > 0 && idx < stim_q.size()) begin
        send_req(stim_q[idx]);
        idx++;
        burst--;
      end
      gap = $urandom_range(0, 15);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
    // let the monitor log the final request
    @(posedge clk);

    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(CYCLE * 1000000);
    $display("TB_ERROR");
    $finish;
  end

endmodule
